### hw/rtl/cvi_pkg.sv
// ----------------------------------------------------------------------------
// cvi_pkg
// Shared types, codes and helpers of the clamped velocity integrator.
// ----------------------------------------------------------------------------
package cvi_pkg;

  localparam int ADDR_W   = 5;
  localparam int MUL_W    = 32;
  localparam int DIV_W    = 64;
  localparam int SQRT_W   = 32;
  localparam int SF_SHIFT = 16;

  localparam logic [16:0] SF_MIN = 17'd655;
  localparam logic [16:0] SF_MAX = 17'd65536;

  localparam logic [2:0] REG_MAX_SPEED    = 3'd0;
  localparam logic [2:0] REG_MAX_FORCE    = 3'd1;
  localparam logic [2:0] REG_MASS         = 3'd2;
  localparam logic [2:0] REG_SMOOTHING_ON = 3'd3;
  localparam logic [2:0] REG_SMOOTH_FACT  = 3'd4;
  localparam logic [2:0] REG_LOCK_Y       = 3'd5;
  localparam logic [2:0] REG_BLOCK_EN     = 3'd6;

  typedef enum logic [1:0] {
    OP_ADD_FORCE = 2'd0,
    OP_TIME_STEP = 2'd1,
    OP_STOP      = 2'd2,
    OP_SET_VEL   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDF,
    ST_LSUM,
    ST_LSQ,
    ST_LSQRT,
    ST_LMUL,
    ST_LDIV,
    ST_TGTM,
    ST_TGTD,
    ST_SMOOTH,
    ST_ESUM,
    ST_STEP,
    ST_OUT
  } st_t;

  typedef struct packed {
    logic [30:0] max_speed;
    logic [30:0] max_force;
    logic [30:0] mass;
    logic        smoothing_on;
    logic [16:0] smoothing_factor;
    logic        lock_y;
    logic        block_enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ov;
  } sat_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  function automatic logic signed [65:0] ext66(input logic signed [31:0] v);
    return {{34{v[31]}}, v};
  endfunction

  function automatic logic signed [65:0] apply_sign(input logic [63:0] m, input logic neg);
    logic signed [65:0] t;
    t = $signed({2'b00, m});
    return neg ? -t : t;
  endfunction

  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    if (v > $signed({34'd0, 32'h7fffffff})) begin
      r.val = 32'h7fffffff;
      r.ov  = 1'b1;
    end else if (v < $signed({{34{1'b1}}, 32'h80000000})) begin
      r.val = 32'h80000000;
      r.ov  = 1'b1;
    end else begin
      r.val = v[31:0];
      r.ov  = 1'b0;
    end
    return r;
  endfunction

endpackage

### hw/rtl/cvi_mul.sv
// ----------------------------------------------------------------------------
// cvi_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cvi_mul import cvi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic                 done,
  output logic [2*MUL_W-1:0]   prod
);

  localparam int CW = $clog2(MUL_W);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [MUL_W-1:0]     mcand;
  logic [2*MUL_W-1:0]   acc;
  logic [MUL_W:0]       hi_sum;

  assign hi_sum = {1'b0, acc[2*MUL_W-1:MUL_W]} + (acc[0] ? {1'b0, mcand} : '0);
  assign prod   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(MUL_W - 1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(MUL_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      mcand <= a;
      acc   <= {{MUL_W{1'b0}}, b};
    end else if (busy) begin
      acc <= {hi_sum, acc[MUL_W-1:1]};
    end
  end

endmodule

### hw/rtl/cvi_div.sv
// ----------------------------------------------------------------------------
// cvi_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cvi_div import cvi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [31:0]       divisor,
  output logic              done,
  output logic [DIV_W-1:0]  quot
);

  localparam int CW = $clog2(DIV_W);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [31:0]       dsr;
  logic [31:0]       rem;
  logic [DIV_W-1:0]  q;
  logic [32:0]       trial;
  logic [33:0]       diff;

  assign trial = {rem, q[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(DIV_W - 1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dsr <= divisor;
      rem <= '0;
      q   <= dividend;
    end else if (busy) begin
      if (!diff[33]) begin
        rem <= diff[31:0];
        q   <= {q[DIV_W-2:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        q   <= {q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

### hw/rtl/cvi_sqrt.sv
// ----------------------------------------------------------------------------
// cvi_sqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module cvi_sqrt import cvi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [2*SQRT_W-1:0]  rad,
  output logic                 done,
  output logic [SQRT_W-1:0]    root
);

  localparam int CW = $clog2(SQRT_W);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [2*SQRT_W-1:0]  n;
  logic [SQRT_W+1:0]    rem;
  logic [SQRT_W-1:0]    res;
  logic [SQRT_W+3:0]    rem_sh;
  logic [SQRT_W+3:0]    trial;

  assign rem_sh = {rem, n[2*SQRT_W-1:2*SQRT_W-2]};
  assign trial  = {2'b00, res, 2'b01};
  assign root   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(SQRT_W - 1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(SQRT_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      n   <= rad;
      rem <= '0;
      res <= '0;
    end else if (busy) begin
      n <= {n[2*SQRT_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem <= (SQRT_W+2)'(rem_sh - trial);
        res <= {res[SQRT_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[SQRT_W+1:0];
        res <= {res[SQRT_W-2:0], 1'b0};
      end
    end
  end

endmodule

### hw/rtl/cvi_cfg.sv
// ----------------------------------------------------------------------------
// cvi_cfg
// Register file on the APB port; clamps the smoothing factor on write.
// ----------------------------------------------------------------------------
module cvi_cfg import cvi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [2:0]  idx;
  logic        wr;
  logic [16:0] sf_in;
  logic [16:0] sf_clamped;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign sf_in  = pwdata[16:0];

  always_comb begin
    sf_clamped = sf_in;
    if (sf_in < SF_MIN) sf_clamped = SF_MIN;
    if (sf_in > SF_MAX) sf_clamped = SF_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_speed        <= 31'd655360;
      cfg.max_force        <= 31'd655360;
      cfg.mass             <= 31'd65536;
      cfg.smoothing_on     <= 1'b0;
      cfg.smoothing_factor <= 17'd65536;
      cfg.lock_y           <= 1'b0;
      cfg.block_enable     <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_MAX_SPEED:    cfg.max_speed        <= pwdata[30:0];
        REG_MAX_FORCE:    cfg.max_force        <= pwdata[30:0];
        REG_MASS:         cfg.mass             <= pwdata[30:0];
        REG_SMOOTHING_ON: cfg.smoothing_on     <= pwdata[0];
        REG_SMOOTH_FACT:  cfg.smoothing_factor <= sf_clamped;
        REG_LOCK_Y:       cfg.lock_y           <= pwdata[0];
        REG_BLOCK_EN:     cfg.block_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_SPEED:    prdata = {1'b0, cfg.max_speed};
      REG_MAX_FORCE:    prdata = {1'b0, cfg.max_force};
      REG_MASS:         prdata = {1'b0, cfg.mass};
      REG_SMOOTHING_ON: prdata = {31'd0, cfg.smoothing_on};
      REG_SMOOTH_FACT:  prdata = {15'd0, cfg.smoothing_factor};
      REG_LOCK_Y:       prdata = {31'd0, cfg.lock_y};
      REG_BLOCK_EN:     prdata = {31'd0, cfg.block_enable};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/clamped_velocity_integrator_top.sv
// ----------------------------------------------------------------------------
// clamped_velocity_integrator_top
// Q-format 3-D velocity integrator with force and speed limits.
//
//   channel  dir  beat contents
//   s_*      in   tuser opcode; tdata vec_x, vec_y, vec_z, weight, time_step
//   m_*      out  tuser moved, overflow; tdata vel_x..z, step_x..z
//   apb      in   seven registers at byte address 4*index
//
// A sequencer drives one serial multiplier, one serial divider and one serial
// square root. Stop, set velocity and a time step that only clears forces go
// straight to the output state; add force and a full time step use the serial
// units; how long a full time step runs depends on which limits engage and
// on smoothing. One beat is in flight at a time; the output register holds a
// result while the next beat is taken.
// rst is synchronous, clears velocity and forces and resets the registers to their defaults.
// ----------------------------------------------------------------------------
module clamped_velocity_integrator_top import cvi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [159:0]      s_tdata,   // vec_x, vec_y, vec_z, weight, time_step
  input  logic [1:0]        s_tuser,   // opcode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [191:0]      m_tdata,   // vel_x, vel_y, vel_z, step_x, step_y, step_z
  output logic [1:0]        m_tuser,   // moved, overflow
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [63:0] EPS_SQ =
    64'(((65'd1 << (2 * FRAC_BITS)) + 65'd99999999) / 65'd100000000);

  cfg_t cfg;

  st_t  state, state_next;
  logic [1:0] k, k_next;
  logic issued, issued_next;
  logic pass, pass_next;
  logic signed [31:0] vin [3];
  logic signed [31:0] vin_next [3];
  logic signed [31:0] w, w_next, dt, dt_next;
  logic signed [31:0] vel [3];
  logic signed [31:0] vel_next [3];
  logic signed [31:0] frc [3];
  logic signed [31:0] frc_next [3];
  logic signed [31:0] wv [3];
  logic signed [31:0] wv_next [3];
  logic signed [31:0] stp [3];
  logic signed [31:0] stp_next [3];
  logic [63:0] ssum, ssum_next;
  logic [63:0] pr, pr_next;
  logic [31:0] mag, mag_next;
  logic ov, ov_next, moved, moved_next;
  logic m_tvalid_next;
  logic [191:0] m_tdata_next;
  logic [1:0] m_tuser_next;

  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  logic        div_start, div_done;
  logic [63:0] div_n, div_q;
  logic [31:0] div_d;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  logic [30:0] lim;
  logic [31:0] massd;
  logic signed [32:0] dif;
  logic [32:0] dif_abs;
  logic [63:0] ssum_acc;
  sat_t sr;

  cvi_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cvi_mul u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .done(mul_done), .prod(mul_prod)
  );

  cvi_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quot(div_q)
  );

  cvi_sqrt u_sqrt (
    .clk, .rst, .start(sq_start), .rad(ssum), .done(sq_done), .root(sq_root)
  );

  assign s_tready = (state == ST_IDLE);
  assign lim      = pass ? cfg.max_speed : cfg.max_force;
  assign massd    = (cfg.mass == 31'd0) ? 32'd1 : {1'b0, cfg.mass};
  assign dif      = {wv[k][31], wv[k]} - {vel[k][31], vel[k]};
  assign dif_abs  = dif[32] ? 33'(-dif) : dif;
  assign ssum_acc = ssum + mul_prod;

  always_comb begin
    state_next   = state;
    k_next       = k;
    issued_next  = issued;
    pass_next    = pass;
    vin_next     = vin;
    w_next       = w;
    dt_next      = dt;
    vel_next     = vel;
    frc_next     = frc;
    wv_next      = wv;
    stp_next     = stp;
    ssum_next    = ssum;
    pr_next      = pr;
    mag_next     = mag;
    ov_next      = ov;
    moved_next   = moved;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next = m_tdata;
    m_tuser_next = m_tuser;
    mul_start    = 1'b0;
    mul_a        = abs32(vel[k]);
    mul_b        = abs32(vel[k]);
    div_start    = 1'b0;
    div_n        = pr;
    div_d        = mag;
    sq_start     = 1'b0;
    sr           = sat32(66'sd0);

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          vin_next[0] = s_tdata[31:0];
          vin_next[1] = s_tdata[63:32];
          vin_next[2] = s_tdata[95:64];
          w_next      = s_tdata[127:96];
          dt_next     = s_tdata[159:128];
          k_next      = 2'd0;
          issued_next = 1'b0;
          pass_next   = 1'b0;
          ssum_next   = '0;
          ov_next     = 1'b0;
          moved_next  = 1'b0;
          stp_next    = '{default: 32'sd0};
          case (op_t'(s_tuser))
            OP_ADD_FORCE: state_next = ST_ADDF;
            OP_STOP: begin
              vel_next   = '{default: 32'sd0};
              frc_next   = '{default: 32'sd0};
              state_next = ST_OUT;
            end
            OP_SET_VEL: begin
              vel_next[0] = s_tdata[31:0];
              vel_next[1] = s_tdata[63:32];
              vel_next[2] = s_tdata[95:64];
              state_next  = ST_OUT;
            end
            OP_TIME_STEP: begin
              if (!cfg.block_enable) begin
                state_next = ST_OUT;
              end else if (s_tdata[159] || (s_tdata[159:128] == 32'd0)) begin
                frc_next   = '{default: 32'sd0};
                state_next = ST_OUT;
              end else begin
                wv_next    = frc;
                state_next = ST_LSUM;
              end
            end
            default: state_next = ST_OUT;
          endcase
        end
      end

      ST_ADDF: begin
        mul_a = abs32(vin[k]);
        mul_b = abs32(w);
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          sr = sat32(ext66(frc[k]) + apply_sign(mul_prod >> FRAC_BITS, vin[k][31] ^ w[31]));
          frc_next[k] = sr.val;
          ov_next     = ov | sr.ov;
          if (k == 2'd2) begin
            k_next     = 2'd0;
            state_next = ST_OUT;
          end else begin
            k_next = k + 2'd1;
          end
        end
      end

      ST_LSUM: begin
        mul_a = abs32(wv[k]);
        mul_b = abs32(wv[k]);
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          ssum_next   = ssum_acc;
          if (k == 2'd2) begin
            k_next     = 2'd0;
            state_next = ST_LSQ;
          end else begin
            k_next = k + 2'd1;
          end
        end
      end

      ST_LSQ: begin
        mul_a = {1'b0, lim};
        mul_b = {1'b0, lim};
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          if (ssum > mul_prod) begin
            state_next = ST_LSQRT;
          end else if (pass) begin
            state_next = ST_SMOOTH;
          end else begin
            state_next = ST_TGTM;
          end
        end
      end

      ST_LSQRT: begin
        if (!issued) begin
          sq_start    = 1'b1;
          issued_next = 1'b1;
        end else if (sq_done) begin
          issued_next = 1'b0;
          mag_next    = sq_root;
          k_next      = 2'd0;
          state_next  = ST_LMUL;
        end
      end

      ST_LMUL: begin
        mul_a = abs32(wv[k]);
        mul_b = {1'b0, lim};
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          pr_next     = mul_prod;
          state_next  = ST_LDIV;
        end
      end

      ST_LDIV: begin
        div_d = mag;
        if (!issued) begin
          div_start   = 1'b1;
          issued_next = 1'b1;
        end else if (div_done) begin
          issued_next = 1'b0;
          wv_next[k]  = wv[k][31] ? 32'(-div_q[31:0]) : div_q[31:0];
          if (k == 2'd2) begin
            k_next     = 2'd0;
            state_next = pass ? ST_SMOOTH : ST_TGTM;
          end else begin
            k_next     = k + 2'd1;
            state_next = ST_LMUL;
          end
        end
      end

      ST_TGTM: begin
        mul_a = abs32(wv[k]);
        mul_b = dt;
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          pr_next     = mul_prod;
          state_next  = ST_TGTD;
        end
      end

      ST_TGTD: begin
        div_d = massd;
        if (!issued) begin
          div_start   = 1'b1;
          issued_next = 1'b1;
        end else if (div_done) begin
          issued_next = 1'b0;
          sr = sat32(ext66(vel[k]) + apply_sign(div_q, wv[k][31]));
          wv_next[k]  = sr.val;
          ov_next     = ov | sr.ov;
          if (k == 2'd2) begin
            if (cfg.lock_y) wv_next[1] = 32'sd0;
            k_next     = 2'd0;
            pass_next  = 1'b1;
            ssum_next  = '0;
            state_next = ST_LSUM;
          end else begin
            k_next     = k + 2'd1;
            state_next = ST_TGTM;
          end
        end
      end

      ST_SMOOTH: begin
        mul_a = dif_abs[31:0];
        mul_b = {15'd0, cfg.smoothing_factor};
        if (!cfg.smoothing_on) begin
          vel_next = wv;
          if (cfg.lock_y) vel_next[1] = 32'sd0;
          ssum_next  = '0;
          k_next     = 2'd0;
          state_next = ST_ESUM;
        end else if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          vel_next[k] = 32'(ext66(vel[k]) + apply_sign(mul_prod >> SF_SHIFT, dif[32]));
          if (k == 2'd2) begin
            if (cfg.lock_y) vel_next[1] = 32'sd0;
            ssum_next  = '0;
            k_next     = 2'd0;
            state_next = ST_ESUM;
          end else begin
            k_next = k + 2'd1;
          end
        end
      end

      ST_ESUM: begin
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          ssum_next   = ssum_acc;
          if (k == 2'd2) begin
            k_next = 2'd0;
            if (ssum_acc < EPS_SQ) begin
              vel_next   = '{default: 32'sd0};
              frc_next   = '{default: 32'sd0};
              state_next = ST_OUT;
            end else begin
              state_next = ST_STEP;
            end
          end else begin
            k_next = k + 2'd1;
          end
        end
      end

      ST_STEP: begin
        mul_b = dt;
        if (!issued) begin
          mul_start   = 1'b1;
          issued_next = 1'b1;
        end else if (mul_done) begin
          issued_next = 1'b0;
          sr = sat32(apply_sign(mul_prod >> FRAC_BITS, vel[k][31]));
          stp_next[k] = sr.val;
          ov_next     = ov | sr.ov;
          moved_next  = moved | (sr.val != 32'd0);
          if (k == 2'd2) begin
            k_next     = 2'd0;
            frc_next   = '{default: 32'sd0};
            state_next = ST_OUT;
          end else begin
            k_next = k + 2'd1;
          end
        end
      end

      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = {stp[2], stp[1], stp[0], vel[2], vel[1], vel[0]};
          m_tuser_next  = {ov, moved};
          state_next    = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      issued   <= 1'b0;
      m_tvalid <= 1'b0;
      vel      <= '{default: 32'sd0};
      frc      <= '{default: 32'sd0};
    end else begin
      state    <= state_next;
      issued   <= issued_next;
      m_tvalid <= m_tvalid_next;
      vel      <= vel_next;
      frc      <= frc_next;
    end
  end

  always_ff @(posedge clk) begin
    k       <= k_next;
    pass    <= pass_next;
    vin     <= vin_next;
    w       <= w_next;
    dt      <= dt_next;
    wv      <= wv_next;
    stp     <= stp_next;
    ssum    <= ssum_next;
    pr      <= pr_next;
    mag     <= mag_next;
    ov      <= ov_next;
    moved   <= moved_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
  end

endmodule

### tb/cvi_checker.sv
// ----------------------------------------------------------------------------
// cvi_checker
// Watches the stream and register ports of the velocity integrator, tracks
// its velocity, force and register state, predicts every result beat and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module cvi_checker import cvi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [159:0]      s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [191:0]      m_tdata,
  input  logic [1:0]        m_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                errors,
  output int                pending
);

  localparam longint unsigned TINY_SQ = ((64'd1 << 32) + 64'd99999999) / 64'd100000000;
  localparam longint unsigned Q_ONE = 64'd1 << 16;

  typedef struct {
    logic [31:0] vel [3];
    logic [31:0] disp [3];
    bit          moved;
    bit          ov;
  } motion_t;

  longint          cur_vel [3];
  longint          force_acc [3];
  longint unsigned lim_speed, lim_force, agent_mass, smooth_fact;
  bit              smooth_on, y_locked, enabled;
  bit              clip_hit;
  motion_t         motion_q [$];

  function automatic longint mul_trunc(longint a, longint unsigned b, longint unsigned d);
    longint unsigned ua, r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    r  = ua * b / d;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clip_hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned len_sq(longint a, longint b, longint c);
    longint unsigned ma, mb, mc;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    mc = (c < 0) ? 64'(-c) : 64'(c);
    return ma * ma + mb * mb + mc * mc;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, pw;
    res = 0;
    pw  = 64'd1 << 62;
    while (pw > n) pw = pw >> 2;
    while (pw != 0) begin
      if (n >= res + pw) begin
        n   = n - (res + pw);
        res = (res >> 1) + pw;
      end else begin
        res = res >> 1;
      end
      pw = pw >> 2;
    end
    return res;
  endfunction

  task automatic cap_len(inout longint v [3], input longint unsigned lim);
    longint unsigned s, m;
    s = len_sq(v[0], v[1], v[2]);
    if (s > lim * lim) begin
      m = root_floor(s);
      for (int i = 0; i < 3; i++) v[i] = mul_trunc(v[i], lim, m);
    end
  endtask

  task automatic predict_motion(input logic [1:0] op, input logic [159:0] d,
                                output motion_t e);
    longint vec [3];
    longint f [3];
    longint tgt [3];
    longint disp [3];
    longint w, dt;
    longint unsigned m;
    bit mv;
    for (int i = 0; i < 3; i++) begin
      vec[i]  = longint'($signed(d[32*i +: 32]));
      disp[i] = 0;
    end
    w  = longint'($signed(d[127:96]));
    dt = longint'($signed(d[159:128]));
    clip_hit = 1'b0;
    mv = 1'b0;
    case (op)
      OP_ADD_FORCE: begin
        for (int i = 0; i < 3; i++)
          force_acc[i] = clip32(force_acc[i] + mul_trunc(vec[i] * w, 1, Q_ONE));
      end
      OP_STOP: begin
        for (int i = 0; i < 3; i++) begin
          cur_vel[i]   = 0;
          force_acc[i] = 0;
        end
      end
      OP_SET_VEL: begin
        for (int i = 0; i < 3; i++) cur_vel[i] = vec[i];
      end
      default: begin
        if (enabled) begin
          if (dt > 0) begin
            m = (agent_mass != 0) ? agent_mass : 1;
            for (int i = 0; i < 3; i++) f[i] = force_acc[i];
            cap_len(f, lim_force);
            for (int i = 0; i < 3; i++)
              tgt[i] = clip32(cur_vel[i] + mul_trunc(f[i], 64'(dt), m));
            if (y_locked) tgt[1] = 0;
            cap_len(tgt, lim_speed);
            for (int i = 0; i < 3; i++) begin
              if (smooth_on)
                cur_vel[i] = cur_vel[i] + mul_trunc(tgt[i] - cur_vel[i], smooth_fact, Q_ONE);
              else
                cur_vel[i] = tgt[i];
            end
            if (y_locked) cur_vel[1] = 0;
            if (len_sq(cur_vel[0], cur_vel[1], cur_vel[2]) < TINY_SQ) begin
              for (int i = 0; i < 3; i++) cur_vel[i] = 0;
            end else begin
              for (int i = 0; i < 3; i++) begin
                disp[i] = clip32(mul_trunc(cur_vel[i], 64'(dt), Q_ONE));
                if (disp[i] != 0) mv = 1'b1;
              end
            end
          end
          for (int i = 0; i < 3; i++) force_acc[i] = 0;
        end
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      e.vel[i]  = 32'(cur_vel[i]);
      e.disp[i] = 32'(disp[i]);
    end
    e.moved = mv;
    e.ov    = clip_hit;
  endtask

  always @(posedge clk) begin : watch
    motion_t e;
    logic [31:0] sf;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cur_vel[i]   = 0;
        force_acc[i] = 0;
      end
      lim_speed   = 655360;
      lim_force   = 655360;
      agent_mass  = 65536;
      smooth_on   = 1'b0;
      smooth_fact = 65536;
      y_locked    = 1'b0;
      enabled     = 1'b1;
      motion_q.delete();
      errors  = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_MAX_SPEED:    lim_speed  = 64'(pwdata[30:0]);
          REG_MAX_FORCE:    lim_force  = 64'(pwdata[30:0]);
          REG_MASS:         agent_mass = 64'(pwdata[30:0]);
          REG_SMOOTHING_ON: smooth_on  = pwdata[0];
          REG_SMOOTH_FACT: begin
            sf = {15'd0, pwdata[16:0]};
            if (sf < 32'(SF_MIN)) sf = 32'(SF_MIN);
            if (sf > 32'(SF_MAX)) sf = 32'(SF_MAX);
            smooth_fact = 64'(sf);
          end
          REG_LOCK_Y:       y_locked   = pwdata[0];
          REG_BLOCK_EN:     enabled    = pwdata[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (motion_q.size() == 0) begin
          $display("%0t unexpected result beat %h / %h", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          e = motion_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            if (m_tdata[32*i +: 32] !== e.vel[i]) begin
              $display("%0t vel[%0d] expected %h actual %h", $time, i, e.vel[i],
                       m_tdata[32*i +: 32]);
              errors++;
            end
            if (m_tdata[96+32*i +: 32] !== e.disp[i]) begin
              $display("%0t step[%0d] expected %h actual %h", $time, i, e.disp[i],
                       m_tdata[96+32*i +: 32]);
              errors++;
            end
          end
          if (m_tuser[0] !== e.moved) begin
            $display("%0t moved expected %b actual %b", $time, e.moved, m_tuser[0]);
            errors++;
          end
          if (m_tuser[1] !== e.ov) begin
            $display("%0t overflow expected %b actual %b", $time, e.ov, m_tuser[1]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_motion(s_tuser, s_tdata, e);
        motion_q.push_back(e);
      end
      pending = motion_q.size();
    end
  end

endmodule

### tb/clamped_velocity_integrator_top_test.sv
// ----------------------------------------------------------------------------
// clamped_velocity_integrator_top_test
// Drives command beats and register writes into the velocity integrator
// across several register settings, with random gaps and back-pressure, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module clamped_velocity_integrator_top_test;
  import cvi_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [159:0]      s_tdata;
  logic [1:0]        s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [191:0]      m_tdata;
  logic [1:0]        m_tuser;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                errors;
  int                pending;
  bit                no_gaps;
  int                rx_beats;
  int                idle_cycles;

  clamped_velocity_integrator_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cvi_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(input op_t op, input logic [31:0] vx, input logic [31:0] vy,
                          input logic [31:0] vz, input logic [31:0] w,
                          input logic [31:0] dt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  <= op;
    s_tdata  <= {dt, w, vz, vy, vx};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_q();
    logic [31:0] s;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2, 3: begin
        s = $urandom_range(0, 2621440);
        return $urandom_range(0, 1) ? -s : s;
      end
      4: begin
        s = $urandom_range(0, 8);
        return $urandom_range(0, 1) ? -s : s;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          default: return 32'hffffffff;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_dt();
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, 131072);
    return pick_q();
  endfunction

  task automatic random_cmds(input int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      if (r < 7)
        send_cmd(OP_ADD_FORCE, pick_q(), pick_q(), pick_q(), pick_q(), $urandom);
      else if (r < 14)
        send_cmd(OP_TIME_STEP, $urandom, $urandom, $urandom, $urandom, pick_dt());
      else if (r < 16)
        send_cmd(OP_STOP, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        send_cmd(OP_SET_VEL, pick_q(), pick_q(), pick_q(), $urandom, $urandom);
    end
  endtask

  initial begin
    m_tready <= 1'b0;
    rx_beats = 0;
    @(negedge rst);
    forever begin : rx_loop
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
      rx_beats++;
      if (rx_beats == 300) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
      end
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_ADD_FORCE;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    no_gaps  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_cmd(OP_SET_VEL, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 32'h0);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000);
    send_cmd(OP_ADD_FORCE, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h0);
    send_cmd(OP_ADD_FORCE, 32'h80000000, 32'h80000000, 32'h1, 32'h80000000, 32'h0);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_cmd(OP_ADD_FORCE, 32'h00030000, 32'hfffe0000, 32'h00010000, 32'h00010000, 32'h0);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000);
    send_cmd(OP_ADD_FORCE, 32'h00050000, 32'h0, 32'hfffb0000, 32'h00008000, 32'h0);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff);
    send_cmd(OP_SET_VEL, 32'h1, 32'hffffffff, 32'h1, 32'h0, 32'h0);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000);
    send_cmd(OP_SET_VEL, 32'h00020000, 32'h00010000, 32'hffff0000, 32'h0, 32'h0);
    send_cmd(OP_ADD_FORCE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h0, 32'h0);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff);
    send_cmd(OP_STOP, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_cmd(OP_TIME_STEP, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000);
    random_cmds(200);
    drain();

    write_reg(REG_MAX_SPEED, 32'hffffffff);
    write_reg(REG_MAX_FORCE, 32'h7fffffff);
    write_reg(REG_MASS, 32'h80000000);
    write_reg(REG_SMOOTHING_ON, 32'h0);
    write_reg(REG_SMOOTH_FACT, 32'h0);
    write_reg(REG_LOCK_Y, 32'h0);
    write_reg(REG_BLOCK_EN, 32'h1);
    random_cmds(200);
    drain();

    write_reg(REG_MAX_SPEED, 32'h0);
    write_reg(REG_MAX_FORCE, 32'h80000000);
    write_reg(REG_MASS, 32'h7fffffff);
    write_reg(REG_SMOOTHING_ON, 32'h1);
    write_reg(REG_SMOOTH_FACT, 32'hffffffff);
    write_reg(REG_LOCK_Y, 32'h1);
    random_cmds(160);
    drain();

    no_gaps = 1'b1;
    write_reg(REG_MAX_SPEED, $urandom);
    write_reg(REG_MAX_FORCE, $urandom);
    write_reg(REG_MASS, 32'h1);
    write_reg(REG_SMOOTHING_ON, $urandom);
    write_reg(REG_SMOOTH_FACT, $urandom_range(0, 70000));
    write_reg(REG_LOCK_Y, 32'h0);
    random_cmds(200);
    drain();
    no_gaps = 1'b0;

    write_reg(REG_BLOCK_EN, 32'hfffffffe);
    random_cmds(120);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(REG_MAX_SPEED, $urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 2000000));
      write_reg(REG_MAX_FORCE, $urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 2000000));
      write_reg(REG_MASS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400000));
      write_reg(REG_SMOOTHING_ON, $urandom);
      write_reg(REG_SMOOTH_FACT, $urandom_range(500, 66000));
      write_reg(REG_LOCK_Y, $urandom);
      write_reg(REG_BLOCK_EN, 32'h1);
      random_cmds(120);
      drain();
    end

    repeat (2000) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
